### rtl/core/stepper_ramp_pulse_generator_unit_assert.svh
// Assertion macros for the stepper ramp pulse generator.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRPG_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("srpg: invariant violated");
`define SRPG_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("srpg: sequence violated");
`else
`define SRPG_ASSERT_HOLD(lbl, cond)
`define SRPG_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

### rtl/core/srpg_pkg.sv
package srpg_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = TBL_AW + 1;
  localparam int KIND_W      = 2;
  localparam int CNT_W       = 16;
  localparam int POS_W       = 16;
  localparam int PER_W       = 8;
  localparam int TIDX_W      = 8;
  localparam int RLEN_W      = 9;
  localparam int SUM_W       = CNT_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [RLEN_W-1:0]    RAMP_LENGTH_RST = 9'd148;
  localparam logic [POS_W-1:0]     WRAP_LIMIT_RST  = 16'd8009;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT  = 2'd1;

  typedef logic [TBL_AW-1:0] idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [PER_W-1:0]  per_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_ORIGIN = 2'd2,
    KIND_TABLE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_ACC   = 3'd1,
    MODE_DEC   = 3'd2,
    MODE_CONST = 3'd3,
    MODE_TURN  = 3'd4
  } mode_t;

  // where the half-period for the current ramp index lives this cycle
  typedef enum logic [1:0] {
    SRC_HOLD = 2'd0,
    SRC_LO   = 2'd1,
    SRC_HI   = 2'd2
  } src_t;

  typedef struct packed {
    kind_t             kind;
    cnt_t              step_count;
    logic              move_ccw;
    logic [TIDX_W-1:0] table_index;
    per_t              table_value;
  } item_t;

  typedef struct packed {
    logic  step_level;
    logic  dir_level;
    pos_t  position;
    mode_t motion_state;
    cnt_t  steps_left;
    logic  step_completed;
  } result_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    per_t data;
  } tbl_wr_t;

  typedef struct packed {
    logic stopped;
    idx_t idx;
    src_t src_next;
  } tbl_ctl_t;

  function automatic len_t eff_len(logic [RLEN_W-1:0] raw);
    len_t r;
    if (raw == '0) begin
      r = len_t'(1);
    end else if ({1'b0, raw} > (RLEN_W + 1)'(TABLE_DEPTH)) begin
      r = len_t'(TABLE_DEPTH);
    end else begin
      r = len_t'(raw);
    end
    return r;
  endfunction

endpackage

### rtl/core/srpg_if.sv
interface srpg_item_if;
  logic                          valid;
  logic                          ready;
  logic [srpg_pkg::KIND_W-1:0]   kind;
  logic [srpg_pkg::CNT_W-1:0]    step_count;
  logic                          move_ccw;
  logic [srpg_pkg::TIDX_W-1:0]   table_index;
  logic [srpg_pkg::PER_W-1:0]    table_value;

  modport source (output valid, kind, step_count, move_ccw, table_index, table_value,
                  input ready);
  modport sink (input valid, kind, step_count, move_ccw, table_index, table_value,
                output ready);
endinterface

interface srpg_result_if;
  logic                          valid;
  logic                          ready;
  logic                          step_level;
  logic                          dir_level;
  logic [srpg_pkg::POS_W-1:0]    position;
  logic [2:0]                    motion_state;
  logic [srpg_pkg::CNT_W-1:0]    steps_left;
  logic                          step_completed;

  modport source (output valid, step_level, dir_level, position, motion_state,
                  steps_left, step_completed, input ready);
  modport sink (input valid, step_level, dir_level, position, motion_state,
                steps_left, step_completed, output ready);
endinterface

interface srpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srpg_pkg::CFG_IDX_W-1:0]   index;
  logic [srpg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/srpg_ram.sv
module srpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write-first on both read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

### rtl/core/srpg_table.sv
module srpg_table (
  input  logic               clk,
  input  logic               rst,
  input  srpg_pkg::tbl_ctl_t ctl,
  input  srpg_pkg::tbl_wr_t  wr,
  input  srpg_pkg::len_t     len,
  output srpg_pkg::per_t     period
);

  import srpg_pkg::*;

  src_t src;
  per_t cur;
  per_t cur_next;
  idx_t addr_a;
  idx_t addr_b;
  per_t rd_a;
  per_t rd_b;

  // port A: next lower entry, or the ramp start while stopped; port B: next higher
  assign addr_a = ctl.stopped ? TBL_AW'(len - len_t'(1)) : ctl.idx - idx_t'(1);
  assign addr_b = ctl.idx + idx_t'(1);

  srpg_ram #(
    .WIDTH (PER_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    case (src)
      SRC_LO:  period = rd_a;
      SRC_HI:  period = rd_b;
      default: period = cur;
    endcase
  end

  assign cur_next = (wr.en && wr.addr == ctl.idx) ? wr.data : period;

  always_ff @(posedge clk) begin
    if (rst) begin
      src <= SRC_HOLD;
    end else begin
      src <= ctl.src_next;
    end
    cur <= cur_next;
  end

endmodule

### rtl/core/srpg_motion.sv
module srpg_motion (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  srpg_pkg::item_t     item,
  input  srpg_pkg::len_t      len,
  input  srpg_pkg::pos_t      spr,
  input  srpg_pkg::per_t      period,
  output srpg_pkg::tbl_ctl_t  ctl,
  output srpg_pkg::tbl_wr_t   wr,
  output srpg_pkg::result_t   result
);

  import srpg_pkg::*;

  mode_t mode, mode_next, mode_fin;
  logic  step_high, step_high_next;
  logic  cur_ccw, cur_ccw_next;
  logic  pend_ccw, pend_ccw_next;
  cnt_t  pend, pend_next, pend_fin;
  cnt_t  remaining, remaining_next, rem_fin;
  idx_t  idx, idx_next;
  per_t  timer, timer_next;
  pos_t  pos, pos_next;
  src_t  src_next;
  logic  fell;

  per_t            timer_inc;
  pos_t            pos_step;
  cnt_t            rem_dec;
  idx_t            idx_dec;
  len_t            idx_inc;
  logic [SUM_W-1:0] sum_acc;
  logic [SUM_W-1:0] sum_dec;

  assign timer_inc = timer + per_t'(1);
  assign rem_dec   = (remaining != '0) ? remaining - cnt_t'(1) : '0;
  assign idx_dec   = idx - idx_t'(1);
  assign idx_inc   = {1'b0, idx} + len_t'(1);
  assign sum_acc   = {1'b0, rem_fin} + SUM_W'(idx_dec);
  assign sum_dec   = {1'b0, rem_fin} + SUM_W'(idx_inc);

  always_comb begin
    if (cur_ccw) begin
      pos_step = (pos != '0) ? pos - pos_t'(1) : spr;
    end else begin
      pos_step = (pos < spr) ? pos + pos_t'(1) : '0;
    end
  end

  always_comb begin
    rem_fin  = rem_dec;
    pend_fin = pend;
    mode_fin = mode;
    if (pend != '0) begin
      if (pend_ccw == cur_ccw) begin
        rem_fin  = pend;
        pend_fin = '0;
      end else begin
        mode_fin = MODE_TURN;
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    step_high_next = step_high;
    cur_ccw_next   = cur_ccw;
    pend_ccw_next  = pend_ccw;
    pend_next      = pend;
    remaining_next = remaining;
    idx_next       = idx;
    timer_next     = timer;
    pos_next       = pos;
    src_next       = SRC_HOLD;
    fell           = 1'b0;
    wr.en          = 1'b0;
    wr.addr        = item.table_index[TBL_AW-1:0];
    wr.data        = item.table_value;

    if (fire) begin
      unique case (item.kind)
        KIND_TICK: begin
          if (mode == MODE_STOP) begin
            if (pend != '0) begin
              remaining_next = pend;
              pend_next      = '0;
              idx_next       = TBL_AW'(len - len_t'(1));
              cur_ccw_next   = pend_ccw;
              mode_next      = MODE_ACC;
              src_next       = SRC_LO;
            end
          end else begin
            timer_next = timer_inc;
            if (timer_inc == period) begin
              timer_next = '0;
              if (!step_high) begin
                step_high_next = 1'b1;
              end else begin
                step_high_next = 1'b0;
                fell           = 1'b1;
                pos_next       = pos_step;
                remaining_next = rem_fin;
                pend_next      = pend_fin;
                unique case (mode_fin)
                  MODE_ACC: begin
                    if (idx != '0) begin
                      idx_next  = idx_dec;
                      src_next  = SRC_LO;
                      mode_next = ({1'b0, idx_dec} <= len && sum_acc > SUM_W'(len))
                                  ? MODE_ACC : MODE_DEC;
                    end else begin
                      mode_next = MODE_CONST;
                    end
                  end
                  MODE_CONST: begin
                    mode_next = (rem_fin > CNT_W'(len)) ? MODE_CONST : MODE_DEC;
                  end
                  MODE_DEC: begin
                    if (idx_inc < len) begin
                      idx_next  = idx_inc[TBL_AW-1:0];
                      src_next  = SRC_HI;
                      mode_next = (sum_dec < SUM_W'(len)) ? MODE_DEC : MODE_ACC;
                    end else begin
                      mode_next = MODE_STOP;
                    end
                  end
                  MODE_TURN: begin
                    if (idx_inc < len) begin
                      idx_next  = idx_inc[TBL_AW-1:0];
                      src_next  = SRC_HI;
                      mode_next = MODE_TURN;
                      if (pend_fin != '1) begin
                        pend_next = pend_fin + cnt_t'(1);
                      end
                    end else begin
                      mode_next = MODE_STOP;
                    end
                  end
                  default: begin
                    mode_next = MODE_STOP;
                  end
                endcase
              end
            end
          end
        end
        KIND_MOVE: begin
          if (item.step_count != '0) begin
            pend_next     = item.step_count;
            pend_ccw_next = item.move_ccw;
          end
        end
        KIND_ORIGIN: begin
          if (!cur_ccw) begin
            pos_next = '0;
          end
        end
        KIND_TABLE: begin
          wr.en = ({1'b0, item.table_index} < (TIDX_W + 1)'(TABLE_DEPTH));
        end
      endcase
    end
  end

  always_comb begin
    result.step_level     = step_high_next;
    result.dir_level      = cur_ccw_next;
    result.position       = pos_next;
    result.motion_state   = mode_next;
    result.steps_left     = remaining_next;
    result.step_completed = fell;
    ctl.stopped           = (mode == MODE_STOP);
    ctl.idx               = idx;
    ctl.src_next          = src_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STOP;
      step_high <= 1'b0;
      cur_ccw   <= 1'b0;
      pend_ccw  <= 1'b0;
      pend      <= '0;
      remaining <= '0;
      idx       <= '0;
      timer     <= '0;
      pos       <= '0;
    end else begin
      mode      <= mode_next;
      step_high <= step_high_next;
      cur_ccw   <= cur_ccw_next;
      pend_ccw  <= pend_ccw_next;
      pend      <= pend_next;
      remaining <= remaining_next;
      idx       <= idx_next;
      timer     <= timer_next;
      pos       <= pos_next;
    end
  end

endmodule

### rtl/core/stepper_ramp_pulse_generator_unit.sv
// Single-axis stepper pulse generator with a trapezoidal ramp. Every transaction on cmd
// (tick, move command, origin event or ramp table write) yields exactly one transaction
// on res, registered the cycle after acceptance; cmd accepts one transaction per cycle
// and holds off only while a result sits unaccepted in the output register. The ramp
// table of half-periods is a RAM with one write and two read ports: the neighbors of the
// current ramp index (or the ramp start while stopped) are read every cycle, so a step
// that moves the index leaves the new half-period ready for the very next tick, and
// table writes are forwarded into that path. The table has no reset and needs no
// clearing pass; an entry must be written before the ramp reaches it. Configuration
// writes on cfg are always accepted and should only be issued while the block is idle.
`include "stepper_ramp_pulse_generator_unit_assert.svh"

module stepper_ramp_pulse_generator_unit (
  input logic           clk,
  input logic           rst,
  srpg_item_if.sink     cmd,
  srpg_result_if.source res,
  srpg_cfg_if.sink      cfg
);

  import srpg_pkg::*;

  logic [RLEN_W-1:0] ramp_length;
  pos_t              wrap_limit;
  len_t              len;
  item_t             item;
  logic              fire;
  logic              res_valid;
  result_t           res_data;
  result_t           result;
  tbl_ctl_t          ctl;
  tbl_wr_t           wr;
  per_t              period;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_length <= RAMP_LENGTH_RST;
      wrap_limit  <= WRAP_LIMIT_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_RAMP_LENGTH) begin
        ramp_length <= cfg.data[RLEN_W-1:0];
      end
      if (cfg.index == CFG_WRAP_LIMIT) begin
        wrap_limit <= cfg.data[POS_W-1:0];
      end
    end
  end

  assign len = eff_len(ramp_length);

  assign item.kind        = kind_t'(cmd.kind);
  assign item.step_count  = cmd.step_count;
  assign item.move_ccw    = cmd.move_ccw;
  assign item.table_index = cmd.table_index;
  assign item.table_value = cmd.table_value;

  assign cmd.ready = !res_valid || res.ready;
  assign fire      = cmd.valid && cmd.ready;

  srpg_motion u_motion (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .len    (len),
    .spr    (wrap_limit),
    .period (period),
    .ctl    (ctl),
    .wr     (wr),
    .result (result)
  );

  srpg_table u_table (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .wr     (wr),
    .len    (len),
    .period (period)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (fire) begin
      res_data <= result;
    end
  end

  assign res.valid          = res_valid;
  assign res.step_level     = res_data.step_level;
  assign res.dir_level      = res_data.dir_level;
  assign res.position       = res_data.position;
  assign res.motion_state   = res_data.motion_state;
  assign res.steps_left     = res_data.steps_left;
  assign res.step_completed = res_data.step_completed;

  `SRPG_ASSERT_NEXT(a_fire_gives_result, fire, res_valid)
  `SRPG_ASSERT_HOLD(a_no_accept_when_full, !(res_valid && !res.ready && cmd.ready))
  `SRPG_ASSERT_HOLD(a_fall_leaves_low, !(res_valid && res_data.step_completed && res_data.step_level))
  `SRPG_ASSERT_HOLD(a_stop_is_low, !(res_valid && res_data.motion_state == MODE_STOP && res_data.step_level))

endmodule
